### rtl/nps_pkg.sv
// Shared types and constants for the non-preemptive priority scheduler.
// Used by the controller, the datapath, the top level and the checker.
`default_nettype none

package nps_pkg;

   localparam int TIME_W = 21;
   localparam int ARR_W  = 16;
   localparam int BUR_W  = 16;
   localparam int PRIO_W = 8;
   localparam int JOB_W  = 7;

   localparam logic [TIME_W-1:0] TIME_MAX = 21'h1FFFFF;

   typedef struct packed {
      logic [ARR_W-1:0]  arrival_time;
      logic [BUR_W-1:0]  burst_time;
      logic [PRIO_W-1:0] priority_req;
      logic              last;
   } nps_req_type;

   typedef struct packed {
      logic [JOB_W-1:0]  job_id;
      logic [TIME_W-1:0] completion_time;
      logic [TIME_W-1:0] turnaround_time;
      logic [TIME_W-1:0] waiting_time;
      logic              final_res;
   } nps_rsp_type;

   // one job record as held in the record memory
   typedef struct packed {
      logic [ARR_W-1:0]  arrival;
      logic [BUR_W-1:0]  burst;
      logic [PRIO_W-1:0] prio;
   } nps_rec_type;

   // controller -> datapath
   typedef struct packed {
      logic load;        // input transfer this cycle
      logic scan_init;   // restart index and pick trackers
      logic scan_en;     // step the scan pipeline
      logic commit;      // apply the pick (or idle jump)
      logic out_cap_tat; // capture completion and turnaround
      logic out_cap_wt;  // load the result register
      logic out_next;    // advance to the next result
      logic set_end;     // clear set state after the final result
   } nps_cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic scan_done;   // last entry evaluated this cycle
      logic found;       // a ready job was picked
      logic sched_last;  // this pick finishes the last job
      logic out_last;    // current result is the final one
   } nps_sts_type;

endpackage

`default_nettype wire

### rtl/nonpreemptive_priority_scheduler.sv
// Non-preemptive priority scheduler, top level.
// Input channel (req_*): one job record per transfer (arrival, burst,
//   priority, last). Records are taken while the block is loading; a record
//   beyond MAX_PROCS is dropped. A transfer with last set closes the set.
// Result channel (rsp_*): one result per job, in load order, final_res on
//   the last one. The block then clears its set state and loads again.
// Scheduling: each decision scans all loaded jobs through the record
//   memory read port; an idle jump costs one more scan. Each result goes
//   through memory read, turnaround, waiting time and hand-off; the
//   hand-off waits while rsp_stall is high.
// req_stall stays high from the last record until the final result is
//   transferred. A stalled result holds its payload and waits.
// Reset (synchronous) empties the job set and returns to loading; the
//   record and completion memories need no clearing.
// Depends on nps_pkg, nps_ctrl, nps_dp and nps_ram.
`default_nettype none

module nonpreemptive_priority_scheduler #(
   parameter int MAX_PROCS = 16
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_stall,
   input  wire nps_pkg::nps_req_type req_data,
   output logic                      rsp_valid,
   input  wire logic                 rsp_stall,
   output nps_pkg::nps_rsp_type      rsp_data
);

   nps_pkg::nps_cmd_type cmd;
   nps_pkg::nps_sts_type sts;

   nps_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_last  (req_data.last),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   nps_dp #(.MAX_PROCS(MAX_PROCS)) u_dp (
      .clock    (clock),
      .reset    (reset),
      .cmd      (cmd),
      .req_data (req_data),
      .sts      (sts),
      .rsp_data (rsp_data)
   );

endmodule

`default_nettype wire

### rtl/nps_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module nps_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                                    clock,
   input  wire logic                                    wr_en,
   input  wire logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]                        wr_data,
   input  wire logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] rd_addr,
   output logic      [WIDTH-1:0]                        rd_data
);

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   logic [WIDTH-1:0] mem_ff [(1 << AW)];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

### rtl/nps_ctrl.sv
// Sequencer for the scheduler: load, scan/pick loop, result output.
// Depends on nps_pkg for the command and status structs.
`default_nettype none

module nps_ctrl (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   input  wire logic                 req_last,
   output logic                      req_stall,
   output logic                      rsp_valid,
   input  wire logic                 rsp_stall,
   input  wire nps_pkg::nps_sts_type sts,
   output nps_pkg::nps_cmd_type      cmd
);

   localparam logic [2:0] S_LOAD     = 3'd0;
   localparam logic [2:0] S_SCAN     = 3'd1;
   localparam logic [2:0] S_DECIDE   = 3'd2;
   localparam logic [2:0] S_OUT_RD   = 3'd3;
   localparam logic [2:0] S_OUT_TAT  = 3'd4;
   localparam logic [2:0] S_OUT_WT   = 3'd5;
   localparam logic [2:0] S_OUT_HOLD = 3'd6;

   logic [2:0] state_ff;
   logic [2:0] state_in;
   logic       req_xfer;
   logic       rsp_xfer;

   assign req_stall = (state_ff != S_LOAD);
   assign rsp_valid = (state_ff == S_OUT_HOLD);
   assign req_xfer  = req_valid && !req_stall;
   assign rsp_xfer  = rsp_valid && !rsp_stall;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         S_LOAD: begin
            cmd.load = req_xfer;
            if (req_xfer && req_last) begin
               cmd.scan_init = 1'b1;
               state_in      = S_SCAN;
            end
         end
         S_SCAN: begin
            cmd.scan_en = 1'b1;
            if (sts.scan_done) begin
               state_in = S_DECIDE;
            end
         end
         S_DECIDE: begin
            cmd.commit    = 1'b1;
            cmd.scan_init = 1'b1;
            state_in      = (sts.found && sts.sched_last) ? S_OUT_RD : S_SCAN;
         end
         S_OUT_RD: begin
            state_in = S_OUT_TAT;
         end
         S_OUT_TAT: begin
            cmd.out_cap_tat = 1'b1;
            state_in        = S_OUT_WT;
         end
         S_OUT_WT: begin
            cmd.out_cap_wt = 1'b1;
            state_in       = S_OUT_HOLD;
         end
         S_OUT_HOLD: begin
            if (rsp_xfer) begin
               if (sts.out_last) begin
                  cmd.set_end = 1'b1;
                  state_in    = S_LOAD;
               end else begin
                  cmd.out_next = 1'b1;
                  state_in     = S_OUT_RD;
               end
            end
         end
         default: begin
            state_in = S_LOAD;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_LOAD;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

`default_nettype wire

### rtl/nps_dp.sv
// Scheduler datapath: job record and completion memories, done flags,
// scan pipeline with pick trackers, time keeping and result register.
// Depends on nps_pkg and nps_ram.
`default_nettype none

module nps_dp #(
   parameter int MAX_PROCS = 16
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire nps_pkg::nps_cmd_type cmd,
   input  wire nps_pkg::nps_req_type req_data,
   output nps_pkg::nps_sts_type      sts,
   output nps_pkg::nps_rsp_type      rsp_data
);

   localparam int AW  = (MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1;
   localparam int CW  = $clog2(MAX_PROCS + 1);
   localparam int TW  = nps_pkg::TIME_W;
   localparam int SW  = nps_pkg::TIME_W + 1;
   localparam int ARW = nps_pkg::ARR_W;
   localparam int PW  = nps_pkg::PRIO_W;
   localparam int BW  = nps_pkg::BUR_W;
   localparam int JW  = nps_pkg::JOB_W;
   localparam int RW  = $bits(nps_pkg::nps_rec_type);

   function automatic logic [TW-1:0] sat_sub(input logic [TW-1:0] a, input logic [TW-1:0] b);
      return (a > b) ? (a - b) : '0;
   endfunction

   // control state
   logic [CW-1:0]        count_ff, count_in;
   logic [CW-1:0]        fin_ff, fin_in;
   logic [TW-1:0]        time_ff, time_in;
   logic [MAX_PROCS-1:0] done_ff, done_in;
   logic [CW-1:0]        idx_ff, idx_in;
   logic                 pv_ff, pv_in;
   logic [CW-1:0]        pidx_ff, pidx_in;
   logic                 found_ff, found_in;

   // pick trackers and result payload
   logic [PW-1:0]        best_prio_ff, best_prio_in;
   logic [AW-1:0]        best_idx_ff, best_idx_in;
   logic [BW-1:0]        best_bur_ff, best_bur_in;
   logic [ARW-1:0]       min_arr_ff, min_arr_in;
   logic [TW-1:0]        ct_ff;
   logic [TW-1:0]        tat_ff;
   logic [BW-1:0]        bur_ff;
   nps_pkg::nps_rsp_type rsp_ff;

   nps_pkg::nps_rec_type rec_wr, rec_rd;
   logic                 rec_we;
   logic                 comp_we;
   logic [TW-1:0]        comp_rd;
   logic [TW-1:0]        time_sum_sat;
   logic [SW-1:0]        time_sum;
   logic                 pend;
   logic                 elig;
   logic                 take;
   logic                 min_take;

   assign rec_we         = cmd.load && (count_ff < CW'(MAX_PROCS));
   assign rec_wr.arrival = req_data.arrival_time;
   assign rec_wr.burst   = req_data.burst_time;
   assign rec_wr.prio    = req_data.priority_req;

   nps_ram #(.WIDTH(RW), .DEPTH(MAX_PROCS)) u_rec_ram (
      .clock   (clock),
      .wr_en   (rec_we),
      .wr_addr (count_ff[AW-1:0]),
      .wr_data (rec_wr),
      .rd_addr (idx_ff[AW-1:0]),
      .rd_data (rec_rd)
   );

   assign time_sum     = {1'b0, time_ff} + SW'(best_bur_ff);
   assign time_sum_sat = (time_sum > SW'(nps_pkg::TIME_MAX)) ? nps_pkg::TIME_MAX
                                                             : time_sum[TW-1:0];
   assign comp_we      = cmd.commit && found_ff;

   nps_ram #(.WIDTH(TW), .DEPTH(MAX_PROCS)) u_comp_ram (
      .clock   (clock),
      .wr_en   (comp_we),
      .wr_addr (best_idx_ff),
      .wr_data (time_sum_sat),
      .rd_addr (idx_ff[AW-1:0]),
      .rd_data (comp_rd)
   );

   // evaluation of the entry whose record arrived this cycle
   assign pend     = pv_ff && !done_ff[pidx_ff[AW-1:0]];
   assign elig     = pend && (TW'(rec_rd.arrival) <= time_ff);
   assign take     = elig && (!found_ff || (rec_rd.prio < best_prio_ff));
   assign min_take = pend && (rec_rd.arrival < min_arr_ff);

   always_comb begin
      count_in     = count_ff;
      fin_in       = fin_ff;
      time_in      = time_ff;
      done_in      = done_ff;
      idx_in       = idx_ff;
      pv_in        = pv_ff;
      pidx_in      = pidx_ff;
      found_in     = found_ff;
      best_prio_in = best_prio_ff;
      best_idx_in  = best_idx_ff;
      best_bur_in  = best_bur_ff;
      min_arr_in   = min_arr_ff;

      if (rec_we) begin
         count_in = count_ff + CW'(1);
      end

      if (cmd.scan_en) begin
         pv_in   = (idx_ff < count_ff);
         pidx_in = idx_ff;
         if (idx_ff < count_ff) begin
            idx_in = idx_ff + CW'(1);
         end
         if (take) begin
            found_in     = 1'b1;
            best_prio_in = rec_rd.prio;
            best_idx_in  = pidx_ff[AW-1:0];
            best_bur_in  = rec_rd.burst;
         end
         if (min_take) begin
            min_arr_in = rec_rd.arrival;
         end
      end

      if (cmd.commit) begin
         if (found_ff) begin
            time_in              = time_sum_sat;
            done_in[best_idx_ff] = 1'b1;
            fin_in               = fin_ff + CW'(1);
         end else begin
            // idle: jump to earliest pending arrival
            time_in = TW'(min_arr_ff);
         end
      end

      if (cmd.scan_init) begin
         idx_in     = '0;
         pv_in      = 1'b0;
         found_in   = 1'b0;
         min_arr_in = '1;
      end

      if (cmd.out_next) begin
         idx_in = idx_ff + CW'(1);
      end

      if (cmd.set_end) begin
         count_in = '0;
         fin_in   = '0;
         time_in  = '0;
         done_in  = '0;
         idx_in   = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         fin_ff   <= '0;
         time_ff  <= '0;
         done_ff  <= '0;
         idx_ff   <= '0;
         pv_ff    <= 1'b0;
         found_ff <= 1'b0;
      end else begin
         count_ff <= count_in;
         fin_ff   <= fin_in;
         time_ff  <= time_in;
         done_ff  <= done_in;
         idx_ff   <= idx_in;
         pv_ff    <= pv_in;
         found_ff <= found_in;
      end
   end

   always_ff @(posedge clock) begin
      pidx_ff      <= pidx_in;
      best_prio_ff <= best_prio_in;
      best_idx_ff  <= best_idx_in;
      best_bur_ff  <= best_bur_in;
      min_arr_ff   <= min_arr_in;
      if (cmd.out_cap_tat) begin
         ct_ff  <= comp_rd;
         tat_ff <= sat_sub(comp_rd, TW'(rec_rd.arrival));
         bur_ff <= rec_rd.burst;
      end
      if (cmd.out_cap_wt) begin
         rsp_ff.job_id          <= JW'(idx_ff) + JW'(1);
         rsp_ff.completion_time <= ct_ff;
         rsp_ff.turnaround_time <= tat_ff;
         rsp_ff.waiting_time    <= sat_sub(tat_ff, TW'(bur_ff));
         rsp_ff.final_res       <= sts.out_last;
      end
   end

   assign sts.scan_done  = pv_ff && ((pidx_ff + CW'(1)) == count_ff);
   assign sts.found      = found_ff;
   assign sts.sched_last = ((fin_ff + CW'(1)) == count_ff);
   assign sts.out_last   = ((idx_ff + CW'(1)) == count_ff);
   assign rsp_data       = rsp_ff;

endmodule

`default_nettype wire

### rtl/nps_chk.sv
// Port-level checker for the scheduler, bound to the top level.
// Depends on nps_pkg and nonpreemptive_priority_scheduler.
`default_nettype none

module nps_chk (
   input wire logic                 clock,
   input wire logic                 reset,
   input wire logic                 req_stall,
   input wire logic                 rsp_valid,
   input wire logic                 rsp_stall,
   input wire nps_pkg::nps_rsp_type rsp_data
);

   // a stalled result stays offered
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> rsp_valid)
      else $error("result dropped while stalled");

   // no record is taken while a result is offered
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> req_stall)
      else $error("input open while result pending");

   // after the final result transfer the block is loading again
   a_final_reload: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_stall && rsp_data.final_res) |=> (!req_stall && !rsp_valid))
      else $error("block not reloading after final result");

   // results are spaced: a non-final transfer is followed by a gap
   a_gap: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_stall && !rsp_data.final_res) |=> !rsp_valid)
      else $error("results back to back");

   // reset leaves the block loading with nothing to show
   a_reset: assert property (@(posedge clock)
      reset |=> (!rsp_valid && !req_stall))
      else $error("bad state after reset");

endmodule

bind nonpreemptive_priority_scheduler nps_chk u_nps_chk (
   .clock     (clock),
   .reset     (reset),
   .req_stall (req_stall),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);

`default_nettype wire

### tb/tb_nonpreemptive_priority_scheduler.sv
// Self-checking testbench for nonpreemptive_priority_scheduler: loads job sets,
// predicts each job's completion, turnaround and waiting time, and checks them.
// Depends on nps_pkg and the scheduler RTL.

module tb_nonpreemptive_priority_scheduler;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int JOBS_MAX   = 16;
   localparam int IDLE_LIMIT = 20000;
   localparam int JOB_TARGET = 370;

   // Holds the job set being loaded and the per-job reports still owed.
   class sched_scoreboard;
      logic [nps_pkg::ARR_W-1:0]  arr_mem[JOBS_MAX];
      logic [nps_pkg::BUR_W-1:0]  bur_mem[JOBS_MAX];
      logic [nps_pkg::PRIO_W-1:0] prio_mem[JOBS_MAX];
      int unsigned                held;
      nps_pkg::nps_rsp_type       report_q[$];
      int unsigned                fails;

      function new();
         held  = 0;
         fails = 0;
      endfunction

      function int unsigned pending();
         return report_q.size();
      endfunction

      function void note_job(nps_pkg::nps_req_type job);
         if (held < JOBS_MAX) begin
            arr_mem[held]  = job.arrival_time;
            bur_mem[held]  = job.burst_time;
            prio_mem[held] = job.priority_req;
            held++;
         end
         if (job.last)
            schedule_set();
      endfunction

      // Run the set to completion from tick 0, queue one report per job in load order.
      function void schedule_set();
         bit                   done[JOBS_MAX];
         int unsigned          finish_at[JOBS_MAX];
         int unsigned          now, finished, pick, best, nxt, tat, wt;
         bit                   found, any;
         nps_pkg::nps_rsp_type rep;
         now      = 0;
         finished = 0;
         pick     = 0;
         best     = 0;
         nxt      = 0;
         foreach (done[i]) begin
            done[i]      = 1'b0;
            finish_at[i] = 0;
         end
         while (finished < held) begin
            found = 1'b0;
            for (int i = 0; i < held; i++) begin
               if (!done[i] && arr_mem[i] <= now && (!found || prio_mem[i] < best)) begin
                  found = 1'b1;
                  best  = prio_mem[i];
                  pick  = i;
               end
            end
            if (found) begin
               now = now + bur_mem[pick];
               if (now > nps_pkg::TIME_MAX)
                  now = nps_pkg::TIME_MAX;
               finish_at[pick] = now;
               done[pick]      = 1'b1;
               finished++;
            end else begin
               // processor idle: jump to the earliest arrival still pending
               any = 1'b0;
               for (int i = 0; i < held; i++) begin
                  if (!done[i] && (!any || arr_mem[i] < nxt)) begin
                     any = 1'b1;
                     nxt = arr_mem[i];
                  end
               end
               now = nxt;
            end
         end
         for (int i = 0; i < held; i++) begin
            tat = (finish_at[i] > arr_mem[i]) ? finish_at[i] - arr_mem[i] : 0;
            wt  = (tat > bur_mem[i]) ? tat - bur_mem[i] : 0;
            rep.job_id          = nps_pkg::JOB_W'(i + 1);
            rep.completion_time = nps_pkg::TIME_W'(finish_at[i]);
            rep.turnaround_time = nps_pkg::TIME_W'(tat);
            rep.waiting_time    = nps_pkg::TIME_W'(wt);
            rep.final_res       = (i + 1 == held);
            report_q.push_back(rep);
         end
         held = 0;
      endfunction

      function void check_result(nps_pkg::nps_rsp_type got);
         nps_pkg::nps_rsp_type want;
         if (report_q.size() == 0) begin
            $error("result for job %0d with no report pending", got.job_id);
            fails++;
            return;
         end
         want = report_q.pop_front();
         if (got.job_id !== want.job_id) begin
            $error("job_id: expected %0d, got %0d", want.job_id, got.job_id);
            fails++;
         end
         if (got.completion_time !== want.completion_time) begin
            $error("completion_time: expected %0d, got %0d",
                   want.completion_time, got.completion_time);
            fails++;
         end
         if (got.turnaround_time !== want.turnaround_time) begin
            $error("turnaround_time: expected %0d, got %0d",
                   want.turnaround_time, got.turnaround_time);
            fails++;
         end
         if (got.waiting_time !== want.waiting_time) begin
            $error("waiting_time: expected %0d, got %0d",
                   want.waiting_time, got.waiting_time);
            fails++;
         end
         if (got.final_res !== want.final_res) begin
            $error("final_res: expected %0d, got %0d", want.final_res, got.final_res);
            fails++;
         end
      endfunction
   endclass

   logic                 clock;
   logic                 reset     = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_stall;
   nps_pkg::nps_req_type req_data  = '0;
   logic                 rsp_valid;
   logic                 rsp_stall = 1'b0;
   nps_pkg::nps_rsp_type rsp_data;

   sched_scoreboard board = new();
   bit              calm;
   int unsigned     jobs_sent;
   int unsigned     idle_cycles = 0;

   nonpreemptive_priority_scheduler #(
      .MAX_PROCS(JOBS_MAX)
   ) u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // mostly short gaps, a few long ones, none during calm stretches
   function automatic int unsigned pick_gap();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (calm || r < 60)
         return 0;
      else if (r < 92)
         return $urandom_range(1, 3);
      else
         return $urandom_range(10, 40);
   endfunction

   function automatic nps_pkg::nps_req_type make_job(int unsigned arr, int unsigned bur,
                                                     int unsigned prio, bit fin);
      nps_pkg::nps_req_type job;
      job.arrival_time = nps_pkg::ARR_W'(arr);
      job.burst_time   = nps_pkg::BUR_W'(bur);
      job.priority_req = nps_pkg::PRIO_W'(prio);
      job.last         = fin;
      return job;
   endfunction

   task automatic send_job(nps_pkg::nps_req_type job);
      int unsigned gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= job;
      do
         @(posedge clock);
      while (req_stall);
      board.note_job(job);
      jobs_sent++;
   endtask

   // hold off the sender until every owed report has been seen
   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (board.pending() != 0)
         @(posedge clock);
   endtask

   // mode 0: tight arrivals and few priorities (ties, queueing)
   // mode 1: full field ranges; mode 2: sparse arrivals, short bursts (idle jumps)
   task automatic random_set(int unsigned count, int unsigned mode);
      nps_pkg::nps_req_type job;
      for (int i = 0; i < count; i++) begin
         case (mode)
            0: job = make_job($urandom_range(0, 40), $urandom_range(0, 20),
                              $urandom_range(0, 7), 1'b0);
            1: job = make_job($urandom, $urandom, $urandom, 1'b0);
            default: job = make_job($urandom_range(0, 65535), $urandom_range(0, 300),
                                    $urandom_range(0, 255), 1'b0);
         endcase
         job.last = (i == count - 1);
         send_job(job);
      end
   endtask

   // result side: random stalls, checked on every transfer
   initial begin
      int unsigned hold;
      int unsigned r;
      hold = 0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && !rsp_stall)
            board.check_result(rsp_data);
         r = $urandom_range(0, 99);
         if (hold > 0) begin
            hold--;
            rsp_stall <= 1'b1;
         end else if (calm || r < 70) begin
            rsp_stall <= 1'b0;
         end else begin
            hold = (r < 95) ? $urandom_range(0, 2) : $urandom_range(9, 39);
            rsp_stall <= 1'b1;
         end
      end
   end

   // watchdog: too long without any transfer ends the run
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   initial begin
      int unsigned r;
      int unsigned count;
      int unsigned sets;
      calm      = 1'b0;
      jobs_sent = 0;
      sets      = 0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // single job at tick 0 with zero burst
      send_job(make_job(0, 0, 0, 1'b1));
      // field extremes, idle jumps to a late arrival, priority tie on the same arrival
      send_job(make_job(65535, 65535, 255, 1'b0));
      send_job(make_job(0, 0, 0, 1'b0));
      send_job(make_job(3, 4, 0, 1'b0));
      send_job(make_job(0, 5, 9, 1'b0));
      send_job(make_job(0, 2, 9, 1'b0));
      send_job(make_job(1, 1, 3, 1'b1));
      drain();
      // store full: two extra records dropped, the dropped last one still starts the run
      for (int i = 0; i < 18; i++)
         send_job(make_job($urandom_range(0, 30), $urandom_range(1, 9),
                           $urandom_range(0, 3), i == 17));

      while (jobs_sent < JOB_TARGET) begin
         r = $urandom_range(0, 99);
         if (r < 70)
            count = $urandom_range(1, 6);
         else if (r < 94)
            count = $urandom_range(7, 16);
         else
            count = $urandom_range(17, 20);
         calm = ($urandom_range(0, 4) == 0);
         random_set(count, $urandom_range(0, 2));
         sets++;
         if (sets == 3 || $urandom_range(0, 5) == 0)
            drain();
      end
      calm = 1'b0;
      req_valid <= 1'b0;

      while (board.pending() != 0)
         @(posedge clock);
      repeat (60) @(posedge clock);
      if (board.fails == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule

### filelist.f
rtl/nps_pkg.sv
rtl/nps_ram.sv
rtl/nps_ctrl.sv
rtl/nps_dp.sv
rtl/nonpreemptive_priority_scheduler.sv
rtl/nps_chk.sv
tb/tb_nonpreemptive_priority_scheduler.sv
